[hdl/adr_pkg.sv]
// shared constants and command types for the dead reckoning chain
package adr_pkg;

    localparam int WINDOW        = 20;
    localparam int SAMPLE_BITS   = 11;
    localparam int DEADBAND_BITS = 8;
    localparam int GAIN_BITS     = 16;
    localparam int MS_BITS       = 16;
    localparam int OUT_BITS      = 32;
    localparam int CFG_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int MS_PER_S      = 1000;
    localparam int Q16_SHIFT     = 16;

    localparam logic [DEADBAND_BITS-1:0] DEADBAND_RESET = DEADBAND_BITS'(3);
    localparam logic [GAIN_BITS-1:0]     GAIN_RESET     = GAIN_BITS'(3213);

    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEL_OFFSET = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEADBAND     = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN         = CFG_IDX_BITS'(2);

    // running sums of the two windows
    localparam int ASUM_BITS = SAMPLE_BITS + $clog2(WINDOW);
    localparam int VSUM_BITS = OUT_BITS + $clog2(WINDOW);

    // serial multiplier: wide multiplicand, one multiplier bit per cycle
    localparam int MUL_A_BITS   = 32;
    localparam int MUL_B_BITS   = 16;
    localparam int PROD_BITS    = MUL_A_BITS + MUL_B_BITS;
    localparam int MUL_CNT_BITS = $clog2(MUL_B_BITS + 1);

    // serial divider: one quotient bit per cycle, small constant divisors
    localparam int DVD_BITS     = PROD_BITS;
    localparam int DVS_BITS     = 10;
    localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);

    // velocity increment: |delta| * gain * ms, then drop the q16 fraction
    localparam int INC_PROD_BITS = SAMPLE_BITS + GAIN_BITS + MS_BITS;
    localparam int INC_DVD_BITS  = INC_PROD_BITS - Q16_SHIFT;

    typedef struct packed {
        logic                  start;
        logic [MUL_A_BITS-1:0] a;
        logic [MUL_B_BITS-1:0] b;
    } mul_cmd_t;

    typedef struct packed {
        logic                    start;
        logic [DVD_BITS-1:0]     dividend;
        logic [DVS_BITS-1:0]     divisor;
        logic [DIV_CNT_BITS-1:0] len;
    } div_cmd_t;

endpackage

[hdl/accel_dead_reckoning_chain.sv]
// one-axis dead reckoning: calibrate, average, integrate velocity, derive distance
//
// One sample beat in gives one result beat out. The sample is offset-corrected,
// zeroed inside the deadband and averaged over a 20-deep window; the change of
// that average times gain and elapsed time updates a saturating velocity, which
// is averaged over a second 20-deep window and scaled by elapsed time into
// distance. All products and quotients come from one bit-serial multiplier and
// one bit-serial divider (one quotient bit per cycle), used in turn, so the
// input stalls from acceptance until the result beat is offered; the next
// sample can be taken in the same cycle that the result is first offered.
// A new sample is taken once the previous result sits in the output register,
// even while that result is still stalled. Both windows clear on reset.
module accel_dead_reckoning_chain
    import adr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] accel_sample,
    input  logic [MS_BITS-1:0]            elapsed_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_BITS-1:0]    velocity,
    output logic signed [OUT_BITS-1:0]    distance,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_MUL_G,
        ST_MUL_T,
        ST_DIV_I,
        ST_VEL,
        ST_PUSH_V,
        ST_LAUNCH_V,
        ST_DIV_V,
        ST_MUL_D,
        ST_DIV_D,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic signed [SAMPLE_BITS-1:0] offset_reg;
    logic [DEADBAND_BITS-1:0]      deadband_reg;
    logic [GAIN_BITS-1:0]          gain_reg;

    logic signed [SAMPLE_BITS-1:0] accel_win_reg [WINDOW];
    logic signed [OUT_BITS-1:0]    vel_win_reg [WINDOW];
    logic signed [ASUM_BITS-1:0]   asum_reg;
    logic signed [VSUM_BITS-1:0]   vsum_reg;
    logic signed [SAMPLE_BITS-1:0] prev_avg_reg;
    logic signed [OUT_BITS-1:0]    vacc_reg;
    logic signed [OUT_BITS:0]      inc_reg;
    logic                          inc_neg_reg;
    logic                          vavg_neg_reg;
    logic [MS_BITS-1:0]            ms_reg;
    logic                          out_valid_reg;
    logic signed [OUT_BITS-1:0]    velocity_reg;
    logic signed [OUT_BITS-1:0]    distance_reg;

    mul_cmd_t             mul_cmd_reg;
    div_cmd_t             div_cmd_reg;
    logic [PROD_BITS-1:0] mul_prod;
    logic                 mul_done;
    logic [DVD_BITS-1:0]  div_quo;
    logic                 div_done;

    logic                          in_take;
    logic [SAMPLE_BITS-1:0]        raw_mag;
    logic [SAMPLE_BITS-1:0]        off_mag;
    logic signed [SAMPLE_BITS:0]   mag_gap;
    logic                          in_band;
    logic signed [SAMPLE_BITS:0]   cal_diff;
    logic signed [SAMPLE_BITS-1:0] cal_sat;
    logic signed [SAMPLE_BITS-1:0] cal;
    logic signed [ASUM_BITS-1:0]   asum_next;
    logic [ASUM_BITS-1:0]          asum_mag;
    logic signed [SAMPLE_BITS-1:0] avg_now;
    logic signed [SAMPLE_BITS:0]   delta;
    logic [SAMPLE_BITS:0]          delta_mag;
    logic signed [OUT_BITS:0]      vacc_sum;
    logic signed [OUT_BITS-1:0]    vacc_next;
    logic [VSUM_BITS-1:0]          vsum_mag;
    logic                          dist_over;
    logic signed [OUT_BITS-1:0]    dist_sat;

    adr_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul_cmd_reg),
        .product (mul_prod),
        .done    (mul_done)
    );

    adr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (div_cmd_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            deadband_reg <= DEADBAND_RESET;
            gain_reg     <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ACCEL_OFFSET: offset_reg   <= cfg_data[SAMPLE_BITS-1:0];
                CFG_DEADBAND:     deadband_reg <= cfg_data[DEADBAND_BITS-1:0];
                CFG_GAIN:         gain_reg     <= cfg_data[GAIN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    // calibration and deadband
    assign raw_mag = accel_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(0) - accel_sample
                                                 : accel_sample;
    assign off_mag = offset_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(0) - offset_reg : offset_reg;
    assign mag_gap = $signed({1'b0, raw_mag}) - $signed({1'b0, off_mag});
    assign in_band = mag_gap < $signed({{(SAMPLE_BITS + 1 - DEADBAND_BITS){1'b0}},
                                        deadband_reg});
    assign cal_diff = (SAMPLE_BITS + 1)'(accel_sample) - (SAMPLE_BITS + 1)'(offset_reg);

    always_comb
    begin
        if (cal_diff[SAMPLE_BITS] != cal_diff[SAMPLE_BITS-1])
            cal_sat = cal_diff[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                                            : {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        else
            cal_sat = cal_diff[SAMPLE_BITS-1:0];
    end

    assign cal       = in_band ? SAMPLE_BITS'(0) : cal_sat;
    assign asum_next = asum_reg - ASUM_BITS'(accel_win_reg[0]) + ASUM_BITS'(cal);
    assign asum_mag  = asum_next[ASUM_BITS-1] ? ASUM_BITS'(0) - asum_next : asum_next;

    // averaged acceleration and its change since the previous item
    assign avg_now   = asum_reg[ASUM_BITS-1] ? SAMPLE_BITS'(0) - div_quo[SAMPLE_BITS-1:0]
                                             : div_quo[SAMPLE_BITS-1:0];
    assign delta     = (SAMPLE_BITS + 1)'(prev_avg_reg) - (SAMPLE_BITS + 1)'(avg_now);
    assign delta_mag = delta[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(0) - delta : delta;

    // saturating velocity update
    assign vacc_sum = (OUT_BITS + 1)'(vacc_reg) + inc_reg;

    always_comb
    begin
        if (vacc_sum[OUT_BITS] != vacc_sum[OUT_BITS-1])
            vacc_next = vacc_sum[OUT_BITS] ? {1'b1, {(OUT_BITS - 1){1'b0}}}
                                           : {1'b0, {(OUT_BITS - 1){1'b1}}};
        else
            vacc_next = vacc_sum[OUT_BITS-1:0];
    end

    assign vsum_mag = vsum_reg[VSUM_BITS-1] ? VSUM_BITS'(0) - vsum_reg : vsum_reg;

    // distance magnitude sits in the divider; the negative side reaches one further
    always_comb
    begin
        if (vavg_neg_reg)
            dist_over = (|div_quo[DVD_BITS-1:OUT_BITS])
                     || (div_quo[OUT_BITS-1] && (|div_quo[OUT_BITS-2:0]));
        else
            dist_over = |div_quo[DVD_BITS-1:OUT_BITS-1];

        if (dist_over)
            dist_sat = vavg_neg_reg ? {1'b1, {(OUT_BITS - 1){1'b0}}}
                                    : {1'b0, {(OUT_BITS - 1){1'b1}}};
        else if (vavg_neg_reg)
            dist_sat = OUT_BITS'(0) - div_quo[OUT_BITS-1:0];
        else
            dist_sat = div_quo[OUT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < WINDOW; i++)
            begin
                accel_win_reg[i] <= '0;
                vel_win_reg[i]   <= '0;
            end
            asum_reg      <= '0;
            vsum_reg      <= '0;
            prev_avg_reg  <= '0;
            vacc_reg      <= '0;
            inc_reg       <= '0;
            inc_neg_reg   <= 1'b0;
            vavg_neg_reg  <= 1'b0;
            ms_reg        <= '0;
            mul_cmd_reg   <= '0;
            div_cmd_reg   <= '0;
            out_valid_reg <= 1'b0;
            velocity_reg  <= '0;
            distance_reg  <= '0;
        end
        else
        begin
            mul_cmd_reg.start <= 1'b0;
            div_cmd_reg.start <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        for (int i = 0; i < WINDOW - 1; i++)
                            accel_win_reg[i] <= accel_win_reg[i+1];
                        accel_win_reg[WINDOW-1] <= cal;
                        asum_reg             <= asum_next;
                        ms_reg               <= elapsed_ms;
                        div_cmd_reg.start    <= 1'b1;
                        div_cmd_reg.dividend <= {asum_mag, {(DVD_BITS - ASUM_BITS){1'b0}}};
                        div_cmd_reg.divisor  <= DVS_BITS'(WINDOW);
                        div_cmd_reg.len      <= DIV_CNT_BITS'(ASUM_BITS);
                        state_reg            <= ST_DIV_A;
                    end
                end
                ST_DIV_A:
                begin
                    if (div_done)
                    begin
                        prev_avg_reg      <= avg_now;
                        inc_neg_reg       <= delta[SAMPLE_BITS];
                        mul_cmd_reg.start <= 1'b1;
                        mul_cmd_reg.a     <= MUL_A_BITS'(delta_mag[SAMPLE_BITS-1:0]);
                        mul_cmd_reg.b     <= gain_reg;
                        state_reg         <= ST_MUL_G;
                    end
                end
                ST_MUL_G:
                begin
                    if (mul_done)
                    begin
                        mul_cmd_reg.start <= 1'b1;
                        mul_cmd_reg.a     <= mul_prod[MUL_A_BITS-1:0];
                        mul_cmd_reg.b     <= ms_reg;
                        state_reg         <= ST_MUL_T;
                    end
                end
                ST_MUL_T:
                begin
                    if (mul_done)
                    begin
                        // q16 fraction is dropped before the divide by 1000
                        div_cmd_reg.start    <= 1'b1;
                        div_cmd_reg.dividend <= {mul_prod[INC_PROD_BITS-1:Q16_SHIFT],
                                                 {(DVD_BITS - INC_DVD_BITS){1'b0}}};
                        div_cmd_reg.divisor  <= DVS_BITS'(MS_PER_S);
                        div_cmd_reg.len      <= DIV_CNT_BITS'(INC_DVD_BITS);
                        state_reg            <= ST_DIV_I;
                    end
                end
                ST_DIV_I:
                begin
                    if (div_done)
                    begin
                        inc_reg   <= inc_neg_reg
                                   ? (OUT_BITS + 1)'(0) - (OUT_BITS + 1)'(div_quo[INC_DVD_BITS-1:0])
                                   : (OUT_BITS + 1)'(div_quo[INC_DVD_BITS-1:0]);
                        state_reg <= ST_VEL;
                    end
                end
                ST_VEL:
                begin
                    vacc_reg  <= vacc_next;
                    vsum_reg  <= vsum_reg - VSUM_BITS'(vel_win_reg[0]);
                    state_reg <= ST_PUSH_V;
                end
                ST_PUSH_V:
                begin
                    for (int i = 0; i < WINDOW - 1; i++)
                        vel_win_reg[i] <= vel_win_reg[i+1];
                    vel_win_reg[WINDOW-1] <= vacc_reg;
                    vsum_reg              <= vsum_reg + VSUM_BITS'(vacc_reg);
                    state_reg             <= ST_LAUNCH_V;
                end
                ST_LAUNCH_V:
                begin
                    vavg_neg_reg         <= vsum_reg[VSUM_BITS-1];
                    div_cmd_reg.start    <= 1'b1;
                    div_cmd_reg.dividend <= {vsum_mag, {(DVD_BITS - VSUM_BITS){1'b0}}};
                    div_cmd_reg.divisor  <= DVS_BITS'(WINDOW);
                    div_cmd_reg.len      <= DIV_CNT_BITS'(VSUM_BITS);
                    state_reg            <= ST_DIV_V;
                end
                ST_DIV_V:
                begin
                    if (div_done)
                    begin
                        mul_cmd_reg.start <= 1'b1;
                        mul_cmd_reg.a     <= div_quo[MUL_A_BITS-1:0];
                        mul_cmd_reg.b     <= ms_reg;
                        state_reg         <= ST_MUL_D;
                    end
                end
                ST_MUL_D:
                begin
                    if (mul_done)
                    begin
                        div_cmd_reg.start    <= 1'b1;
                        div_cmd_reg.dividend <= mul_prod;
                        div_cmd_reg.divisor  <= DVS_BITS'(MS_PER_S);
                        div_cmd_reg.len      <= DIV_CNT_BITS'(DVD_BITS);
                        state_reg            <= ST_DIV_D;
                    end
                end
                ST_DIV_D:
                begin
                    if (div_done)
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // wait until the output register is free or being taken
                    if (!out_valid_reg || !out_stall)
                    begin
                        velocity_reg  <= vacc_reg;
                        distance_reg  <= dist_sat;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign velocity  = velocity_reg;
    assign distance  = distance_reg;

endmodule

[hdl/adr_mul.sv]
// bit-serial shift-add multiplier, multiplier msb first
module adr_mul
    import adr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mul_cmd_t             cmd,
    output logic [PROD_BITS-1:0] product,
    output logic                 done
);

    logic [PROD_BITS-1:0]    acc_reg;
    logic [PROD_BITS-1:0]    acc_next;
    logic [MUL_A_BITS-1:0]   a_reg;
    logic [MUL_B_BITS-1:0]   b_reg;
    logic [MUL_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    assign acc_next = {acc_reg[PROD_BITS-2:0], 1'b0}
                    + (b_reg[MUL_B_BITS-1] ? PROD_BITS'(a_reg) : PROD_BITS'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= MUL_CNT_BITS'(MUL_B_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - MUL_CNT_BITS'(1);
            if (cnt_reg == MUL_CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg <= '0;
            a_reg   <= cmd.a;
            b_reg   <= cmd.b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[MUL_B_BITS-2:0], 1'b0};
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

[hdl/adr_div.sv]
// bit-serial restoring divider, quotient shifts in where the dividend shifts out
module adr_div
    import adr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  div_cmd_t            cmd,
    output logic [DVD_BITS-1:0] quotient,
    output logic                done
);

    logic [DVD_BITS-1:0]     dvd_reg;
    logic [DVS_BITS-1:0]     dvs_reg;
    logic [DVS_BITS-1:0]     rem_reg;
    logic [DVS_BITS-1:0]     rem_next;
    logic [DVS_BITS:0]       trial;
    logic [DVS_BITS:0]       trial_sub;
    logic                    fits;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    assign trial     = {rem_reg, dvd_reg[DVD_BITS-1]};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};
    // remainder stays below the divisor, so the top bit drops in both arms
    assign rem_next  = fits ? trial_sub[DVS_BITS-1:0] : trial[DVS_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= cmd.len;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dvd_reg <= cmd.dividend;
            dvs_reg <= cmd.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_BITS-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

[hdl/adr_checker.sv]
// port-level checks for the dead reckoning chain, bound to the top level
module adr_checker
    import adr_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [OUT_BITS-1:0] velocity,
    input logic signed [OUT_BITS-1:0] distance
);

    // an accepted beat keeps the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted but block not busy afterwards");

    // a result only appears at the end of a busy stretch
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in work");

    // finishing an item always leaves its result in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("block went idle without a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(velocity) && $stable(distance))
        else $error("stalled result beat changed");

endmodule

bind accel_dead_reckoning_chain adr_checker u_adr_checker (.*);
